/* rtl/cdq_pkg.sv */
// Types and codes shared by the circular deque modules.
package cdq_pkg;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic               now_empty;
        logic               now_full;
    } res_t;

    typedef struct packed {
        logic       done;
        logic       pop_ok;
        logic [1:0] status;
        logic       now_empty;
        logic       now_full;
    } flags_t;

endpackage

/* rtl/cdq_mem.sv */
// Entry store: one write port, one read port with registered read data.
module cdq_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [31:0]       wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cdq_ctrl.sv */
// Head/tail/empty bookkeeping, store access requests and result flags.
module cdq_ctrl #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        command,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic              re,
    output logic [AW-1:0]     raddr,
    output cdq_pkg::flags_t   flags
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic          done_reg, done_next;
    logic          pop_ok_reg, pop_ok_next;
    logic [1:0]    status_reg, status_next;
    logic          full;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST : i - AW'(1);
    endfunction

    assign full = !empty_reg && (idx_inc(tail_reg) == head_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        done_next   = accept;
        pop_ok_next = 1'b0;
        status_next = cdq_pkg::ST_DONE;
        we          = 1'b0;
        waddr       = '0;
        re          = 1'b0;
        raddr       = head_reg;
        if (accept)
        begin
            case (command) inside
                cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = cdq_pkg::ST_OVERFLOW;
                    end
                    else if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        we         = 1'b1;
                        waddr      = '0;
                    end
                    else if (command == cdq_pkg::CMD_PUSH_FRONT)
                    begin
                        head_next = idx_dec(head_reg);
                        we        = 1'b1;
                        waddr     = idx_dec(head_reg);
                    end
                    else
                    begin
                        tail_next = idx_inc(tail_reg);
                        we        = 1'b1;
                        waddr     = idx_inc(tail_reg);
                    end
                end
                cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK:
                begin
                    if (empty_reg)
                    begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        re          = 1'b1;
                        pop_ok_next = 1'b1;
                        raddr = (command == cdq_pkg::CMD_POP_FRONT) ? head_reg : tail_reg;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (command == cdq_pkg::CMD_POP_FRONT)
                        begin
                            head_next = idx_inc(head_reg);
                        end
                        else
                        begin
                            tail_next = idx_dec(tail_reg);
                        end
                    end
                end
                default:
                begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
            status_reg <= cdq_pkg::ST_DONE;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            done_reg   <= done_next;
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
        end
    end

    // state registers already hold the post-command state in the result cycle
    assign flags.done      = done_reg;
    assign flags.pop_ok    = pop_ok_reg;
    assign flags.status    = status_reg;
    assign flags.now_empty = empty_reg;
    assign flags.now_full  = full;

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty deque with nonzero indices");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= LAST) && (tail_reg <= LAST))
        else $error("index out of range");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == cdq_pkg::ST_OVERFLOW) |-> full)
        else $error("overflow reported while not full");

    a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == cdq_pkg::ST_UNDERFLOW) |-> empty_reg)
        else $error("underflow reported while not empty");

    a_pop_rd: assert property (@(posedge clk) disable iff (!rst_n)
        re |=> (done_reg && pop_ok_reg))
        else $error("store read without a good pop result");

endmodule

/* rtl/circular_deque.sv */
// Circular double-ended queue: top level.
// Usage:
//   A command item (push front, push back, pop front, pop back, plus the
//   element for pushes) is taken on cmd at a rising edge where start is high
//   and busy is low. busy stays low: a command may be issued every cycle.
//   Each command gives exactly one result item on result, marked by done,
//   in the cycle after the command is taken (throughput 1 item per cycle).
//   The result waits on the registered read of the entry store; indices
//   are updated at the accept edge, so the next command sees them at once
//   and pushes and pops never touch the store in the same cycle.
//   result carries the popped element (zero unless a good pop), a status
//   (done, overflow on push, underflow on pop) and the empty and full flags
//   after the command. A push onto a full deque or a pop from an empty one
//   changes nothing.
//   Reset leaves the deque empty with both indices at zero; the entry store
//   is not cleared. The receiver cannot stall: done lasts one cycle.
module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cdq_pkg::cmd_t   cmd,
    output logic            done,
    output cdq_pkg::res_t   result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic            we;
    logic [AW-1:0]   waddr;
    logic            re;
    logic [AW-1:0]   raddr;
    logic [31:0]     rdata;
    cdq_pkg::flags_t flags;

    assign busy = 1'b0;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (start && !busy),
        .command (cmd.command),
        .we      (we),
        .waddr   (waddr),
        .re      (re),
        .raddr   (raddr),
        .flags   (flags)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.push_value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign done             = flags.done;
    assign result.pop_value = flags.pop_ok ? rdata : 32'sd0;
    assign result.status    = flags.status;
    assign result.now_empty = flags.now_empty;
    assign result.now_full  = flags.now_full;

endmodule

/* tb/testbench.sv */
// Testbench for circular_deque: directed table plus random commands checked by a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = 8;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 406;

    typedef struct {
        cdq_pkg::cmd_t item;
        bit            fixed;
        cdq_pkg::res_t want;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    cdq_pkg::cmd_t cmd;
    logic          done;
    cdq_pkg::res_t result;

    // typed expectation travels with the item it belongs to
    logic          row_fixed;
    cdq_pkg::res_t row_res;

    logic [31:0] deque_store [DEPTH];
    int unsigned deque_head;
    int unsigned deque_tail;
    bit          deque_empty;

    cdq_pkg::res_t pending_results [$];
    dir_row_t      dir_rows [$];
    int            fail_count;
    int            cycle_count;
    int            gap_pct;

    circular_deque #(.DEPTH(DEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned wrap_next(int unsigned i);
        return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function automatic int unsigned wrap_prev(int unsigned i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic bit deque_full();
        return !deque_empty && wrap_next(deque_tail) == deque_head;
    endfunction

    // Applies one command to the deque image and returns the result it gives.
    function automatic cdq_pkg::res_t deque_apply(cdq_pkg::cmd_t c);
        cdq_pkg::res_t r;
        r = '0;
        r.status = cdq_pkg::ST_DONE;
        if (c.command == cdq_pkg::CMD_PUSH_FRONT || c.command == cdq_pkg::CMD_PUSH_BACK)
        begin
            if (deque_full())
                r.status = cdq_pkg::ST_OVERFLOW;
            else if (deque_empty)
            begin
                deque_head = 0;
                deque_tail = 0;
                deque_empty = 1'b0;
                deque_store[0] = c.push_value;
            end
            else if (c.command == cdq_pkg::CMD_PUSH_FRONT)
            begin
                deque_head = wrap_prev(deque_head);
                deque_store[deque_head] = c.push_value;
            end
            else
            begin
                deque_tail = wrap_next(deque_tail);
                deque_store[deque_tail] = c.push_value;
            end
        end
        else if (deque_empty)
            r.status = cdq_pkg::ST_UNDERFLOW;
        else
        begin
            r.pop_value = deque_store[(c.command == cdq_pkg::CMD_POP_FRONT) ?
                                      deque_head : deque_tail];
            if (deque_head == deque_tail)
            begin
                deque_head = 0;
                deque_tail = 0;
                deque_empty = 1'b1;
            end
            else if (c.command == cdq_pkg::CMD_POP_FRONT)
                deque_head = wrap_next(deque_head);
            else
                deque_tail = wrap_prev(deque_tail);
        end
        r.now_empty = deque_empty;
        r.now_full  = deque_full();
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        cdq_pkg::res_t want;
        cdq_pkg::res_t predicted;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no command pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.pop_value !== result.pop_value)
                    begin
                        $error("pop_value expected %0d got %0d", want.pop_value, result.pop_value);
                        fail_count++;
                    end
                    if (want.status !== result.status)
                    begin
                        $error("status expected %0d got %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (want.now_empty !== result.now_empty)
                    begin
                        $error("now_empty expected %0d got %0d", want.now_empty, result.now_empty);
                        fail_count++;
                    end
                    if (want.now_full !== result.now_full)
                    begin
                        $error("now_full expected %0d got %0d", want.now_full, result.now_full);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = deque_apply(cmd);
                pending_results.push_back(row_fixed ? row_res : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_row(logic [1:0] op, logic [31:0] v, bit fx,
                           logic [31:0] pv, logic [1:0] st, bit e, bit f);
        dir_row_t row;
        row.item.command    = op;
        row.item.push_value = v;
        row.fixed           = fx;
        row.want.pop_value  = pv;
        row.want.status     = st;
        row.want.now_empty  = e;
        row.want.now_full   = f;
        dir_rows.push_back(row);
    endtask

    // Presents one item, with random gaps before it, and waits until it is taken.
    task automatic send_item(cdq_pkg::cmd_t c, bit fx, cdq_pkg::res_t r);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        row_fixed <= fx;
        row_res   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, int pct);
        cdq_pkg::cmd_t c;
        int            mode;
        int            push_pct;
        gap_pct = pct;
        mode = 2;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                mode = $urandom_range(2);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            if ($urandom_range(99) < push_pct)
                c.command = $urandom_range(1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
            else
                c.command = $urandom_range(1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
            c.push_value = pick_value();
            send_item(c, 1'b0, '0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        row_fixed   = 1'b0;
        row_res     = '0;
        fail_count  = 0;
        cycle_count = 0;
        gap_pct     = 0;
        deque_head  = 0;
        deque_tail  = 0;
        deque_empty = 1'b1;
        foreach (deque_store[i])
            deque_store[i] = '0;

        //      command, push_value
        //      fixed, pop_value, status, e, f
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h0000_0011,
                1, 32'h0, cdq_pkg::ST_UNDERFLOW, 1, 0);
        add_row(cdq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF,
                1, 32'h0, cdq_pkg::ST_UNDERFLOW, 1, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF,
                1, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h0,
                1, 32'h7FFF_FFFF, cdq_pkg::ST_DONE, 1, 0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000,
                1, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_BACK, 32'h0,
                1, 32'h8000_0000, cdq_pkg::ST_DONE, 1, 0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'h0000_0001,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'hAAAA_AAAA,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0001,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFE,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'h1234_5678,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_PUSH_BACK, 32'hDEAD_BEEF,
                1, 32'h0, cdq_pkg::ST_OVERFLOW, 0, 1);
        add_row(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF,
                1, 32'h0, cdq_pkg::ST_OVERFLOW, 0, 1);
        add_row(cdq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h0,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'hAAAA_AAAA,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_BACK, 32'h5555_5555,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h0,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_BACK, 32'h0,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h0,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_BACK, 32'h0,
                0, 32'h0, cdq_pkg::ST_DONE, 0, 0);
        add_row(cdq_pkg::CMD_POP_FRONT, 32'h8000_0000,
                1, 32'h0, cdq_pkg::ST_UNDERFLOW, 1, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
        wait_drained();

        // sender gap mix: none, heavy, light, none again
        random_phase(PHASE_ITEMS, 0);
        random_phase(PHASE_ITEMS, 49);
        random_phase(PHASE_ITEMS, 18);
        random_phase(PHASE_ITEMS, 0);

        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
